@@ rtl/core/rgb_matrix_row_scan_driver_core_assert.svh @@
// Assertion macros used by the row-scan driver back end.
`ifndef RGB_MATRIX_ROW_SCAN_DRIVER_CORE_ASSERT_SVH
`define RGB_MATRIX_ROW_SCAN_DRIVER_CORE_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define RMRS_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("rmrs assertion failed");

// Next-cycle implication, checked out of reset.
`define RMRS_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("rmrs assertion failed");

`endif

@@ rtl/core/rmrs_pkg.sv @@
// Shared types and constants of the row-scan driver.
`default_nettype none
package rmrs_pkg;
	localparam int CFG_W      = 7;
	localparam int PADDR_W    = 3;
	localparam int PDATA_W    = 32;
	localparam int PIX_ADDR_W = 12;
	localparam int COLOR_W    = 3;
	localparam int ROW_W      = 5;
	localparam int HALF_W     = 6;

	localparam int CMDQ_DEPTH  = 4;
	localparam int OUTQ_DEPTH  = 4;
	localparam int OUTQ_LVL_W  = $clog2(OUTQ_DEPTH) + 1;

	typedef struct packed {
		logic                  is_tick;
		logic                  wr_ok;
		logic [PIX_ADDR_W-1:0] addr;
		logic [COLOR_W-1:0]    color;
	} cmd_t;

	typedef struct packed {
		logic [COLOR_W-1:0] top_rgb;
		logic [COLOR_W-1:0] bottom_rgb;
		logic               shift_clock;
		logic               latch;
		logic               blank;
		logic [ROW_W-1:0]   row_address;
	} res_t;

	localparam int CMD_W = $bits(cmd_t);
	localparam int RES_W = $bits(res_t);
endpackage
`default_nettype wire

@@ rtl/core/rmrs_fifo.sv @@
// Small register-based queue, used between front and back and on the result side.
`default_nettype none
module rmrs_fifo #(
	parameter int WIDTH = 1,
	parameter int DEPTH = 4
) (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     push,
	input  wire logic [WIDTH-1:0]         wdata,
	output logic                          full,
	input  wire logic                     pop,
	output logic [WIDTH-1:0]              rdata,
	output logic                          empty,
	output logic [$clog2(DEPTH):0]        level
);
	localparam int PTR_W = $clog2(DEPTH);

	logic [WIDTH-1:0] slot_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [PTR_W:0]   level_q;
	logic             do_push;
	logic             do_pop;

	assign full    = (level_q == (PTR_W+1)'(DEPTH));
	assign empty   = (level_q == '0);
	assign level   = level_q;
	assign rdata   = slot_q[rd_ptr_q];
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			level_q  <= '0;
		end else begin
			if (do_push) wr_ptr_q <= wr_ptr_q + 1'b1;
			if (do_pop) rd_ptr_q <= rd_ptr_q + 1'b1;
			if (do_push && !do_pop) level_q <= level_q + 1'b1;
			else if (do_pop && !do_push) level_q <= level_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) slot_q[wr_ptr_q] <= wdata;
	end
endmodule
`default_nettype wire

@@ rtl/core/rmrs_front.sv @@
// Front end: input beats, configuration registers, command classification.
`default_nettype none
module rmrs_front
	import rmrs_pkg::*;
#(
	parameter int STORE_DEPTH = 4096,
	parameter int MAX_WIDTH   = 64,
	parameter int COL_W       = 7
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  push,
	output logic                       full,
	input  wire logic                  operation,
	input  wire logic [PIX_ADDR_W-1:0] pixel_address,
	input  wire logic [COLOR_W-1:0]    pixel_color,
	input  wire logic                  psel,
	input  wire logic                  penable,
	input  wire logic                  pwrite,
	input  wire logic [PADDR_W-1:0]    paddr,
	input  wire logic [PDATA_W-1:0]    pwdata,
	output logic [PDATA_W-1:0]         prdata,
	output logic                       pready,
	input  wire logic                  cmdq_full,
	input  wire logic                  clr_busy,
	output logic                       cmd_push,
	output cmd_t                       cmd_data,
	output logic [COL_W-1:0]           eff_width,
	output logic [ROW_W-1:0]           half_mask
);
	localparam logic REG_PANEL_WIDTH  = 1'b0;
	localparam logic REG_PANEL_HEIGHT = 1'b1;

	logic [CFG_W-1:0] panel_width_q;
	logic [CFG_W-1:0] panel_height_q;
	logic [COL_W-1:0] eff_width_q;
	logic [ROW_W-1:0] half_mask_q;
	logic             cfg_wr;
	logic             reg_sel;

	function automatic logic [COL_W-1:0] clamp_width(input logic [CFG_W-1:0] pw);
		logic [COL_W-1:0] w;
		if (pw == '0) w = COL_W'(1);
		else if (32'(pw) > MAX_WIDTH) w = COL_W'(MAX_WIDTH);
		else w = COL_W'(pw);
		return w;
	endfunction

	// largest power of two not above height/2, kept as a row mask (1..32 rows)
	function automatic logic [ROW_W-1:0] row_mask(input logic [CFG_W-1:0] ph);
		logic [HALF_W-1:0] h;
		logic [ROW_W-1:0]  m;
		h = ph[CFG_W-1:1];
		if (h >= HALF_W'(32)) m = ROW_W'(31);
		else if (h >= HALF_W'(16)) m = ROW_W'(15);
		else if (h >= HALF_W'(8)) m = ROW_W'(7);
		else if (h >= HALF_W'(4)) m = ROW_W'(3);
		else if (h >= HALF_W'(2)) m = ROW_W'(1);
		else m = '0;
		return m;
	endfunction

	assign pready  = 1'b1;
	assign reg_sel = paddr[PADDR_W-1];
	assign cfg_wr  = psel && penable && pwrite && pready;

	always_comb begin
		case (reg_sel)
			REG_PANEL_WIDTH: prdata = PDATA_W'(panel_width_q);
			REG_PANEL_HEIGHT: prdata = PDATA_W'(panel_height_q);
			default: prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			panel_width_q  <= CFG_W'(32);
			panel_height_q <= CFG_W'(32);
			eff_width_q    <= clamp_width(CFG_W'(32));
			half_mask_q    <= row_mask(CFG_W'(32));
		end else if (cfg_wr) begin
			case (reg_sel)
				REG_PANEL_WIDTH: begin
					panel_width_q <= pwdata[CFG_W-1:0];
					eff_width_q   <= clamp_width(pwdata[CFG_W-1:0]);
				end
				REG_PANEL_HEIGHT: begin
					panel_height_q <= pwdata[CFG_W-1:0];
					half_mask_q    <= row_mask(pwdata[CFG_W-1:0]);
				end
				default: begin
				end
			endcase
		end
	end

	assign eff_width = eff_width_q;
	assign half_mask = half_mask_q;

	// no beats taken while the frame store is being cleared
	assign full = cmdq_full || clr_busy;

	always_comb begin
		cmd_data.is_tick = operation;
		cmd_data.wr_ok   = !operation && (32'(pixel_address) < STORE_DEPTH);
		cmd_data.addr    = pixel_address;
		cmd_data.color   = pixel_color;
	end

	// writes outside the store have no effect and are dropped here
	assign cmd_push = push && !full && (cmd_data.is_tick || cmd_data.wr_ok);
endmodule
`default_nettype wire

@@ rtl/core/rmrs_back.sv @@
// Back end: frame store, scan sequencer and pixel read stage.
`default_nettype none
`include "rgb_matrix_row_scan_driver_core_assert.svh"
module rmrs_back
	import rmrs_pkg::*;
#(
	parameter int STORE_DEPTH = 4096,
	parameter int COL_W       = 7,
	parameter int IDX_W       = 12
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cmd_empty,
	input  wire cmd_t                  cmd_data,
	output logic                       cmd_pop,
	input  wire logic [COL_W-1:0]      eff_width,
	input  wire logic [ROW_W-1:0]      half_mask,
	input  wire logic [OUTQ_LVL_W-1:0] out_level,
	output logic                       res_push,
	output res_t                       res_data,
	output logic                       clr_busy
);
	localparam int SADDR_W = $clog2(STORE_DEPTH);
	localparam int EXT_A   = (IDX_W > SADDR_W) ? IDX_W : SADDR_W;
	localparam int EXT_W   = (EXT_A > PIX_ADDR_W) ? EXT_A : PIX_ADDR_W;

	localparam logic [1:0] PH_DATA  = 2'd0;
	localparam logic [1:0] PH_CLOCK = 2'd1;
	localparam logic [1:0] PH_BLANK = 2'd2;
	localparam logic [1:0] PH_LATCH = 2'd3;

	logic [COLOR_W-1:0] store_mem [STORE_DEPTH];

	logic [1:0]         phase_q;
	logic [ROW_W-1:0]   scan_row_q;
	logic [COL_W-1:0]   col_q;
	logic [ROW_W-1:0]   shown_q;
	logic               clr_busy_q;
	logic [SADDR_W-1:0] clr_addr_q;

	logic               valid_s1;
	logic               top_ok_s1;
	logic               bot_ok_s1;
	logic [COLOR_W-1:0] top_pix_s1;
	logic [COLOR_W-1:0] bot_pix_s1;
	logic               clk_s1;
	logic               lat_s1;
	logic               blk_s1;
	logic [ROW_W-1:0]   addr_s1;

	logic                  room;
	logic                  tick_go;
	logic                  wr_go;
	logic [HALF_W-1:0]     half;
	logic [ROW_W-1:0]      row;
	logic [COL_W-1:0]      col_sel;
	logic [COL_W:0]        col_inc;
	logic [IDX_W-1:0]      top_idx;
	logic [IDX_W-1:0]      bot_idx;
	logic [EXT_W-1:0]      top_ext;
	logic [EXT_W-1:0]      bot_ext;
	logic [EXT_W-1:0]      wr_ext;
	logic [SADDR_W-1:0]    top_ra;
	logic [SADDR_W-1:0]    bot_ra;
	logic                  pix_phase;
	logic                  mem_we;
	logic [SADDR_W-1:0]    mem_wa;
	logic [COLOR_W-1:0]    mem_wd;

	logic [1:0]         phase_d;
	logic [ROW_W-1:0]   scan_row_d;
	logic [COL_W-1:0]   col_d;
	logic [ROW_W-1:0]   shown_d;
	logic               pin_clk;
	logic               pin_lat;
	logic               pin_blk;
	logic [ROW_W-1:0]   pin_addr;

	// a tick issues only if its result is sure to find a slot
	assign room = ((OUTQ_LVL_W+1)'(out_level) + (OUTQ_LVL_W+1)'(valid_s1))
		< (OUTQ_LVL_W+1)'(OUTQ_DEPTH);
	assign cmd_pop = !clr_busy_q && !cmd_empty && (!cmd_data.is_tick || room);
	assign tick_go = cmd_pop && cmd_data.is_tick;
	assign wr_go   = cmd_pop && !cmd_data.is_tick && cmd_data.wr_ok;

	assign half      = HALF_W'(half_mask) + HALF_W'(1);
	assign row       = scan_row_q & half_mask;
	assign col_sel   = (col_q >= eff_width) ? (eff_width - COL_W'(1)) : col_q;
	assign col_inc   = (COL_W+1)'(col_q) + (COL_W+1)'(1);
	assign pix_phase = (phase_q == PH_DATA) || (phase_q == PH_CLOCK);

	assign top_idx = IDX_W'(row) * IDX_W'(eff_width) + IDX_W'(col_sel);
	assign bot_idx = IDX_W'(HALF_W'(row) + half) * IDX_W'(eff_width) + IDX_W'(col_sel);
	assign top_ext = EXT_W'(top_idx);
	assign bot_ext = EXT_W'(bot_idx);
	assign wr_ext  = EXT_W'(cmd_data.addr);
	assign top_ra  = top_ext[SADDR_W-1:0];
	assign bot_ra  = bot_ext[SADDR_W-1:0];

	always_comb begin
		phase_d    = phase_q;
		scan_row_d = scan_row_q;
		col_d      = col_q;
		shown_d    = shown_q;
		pin_clk    = 1'b0;
		pin_lat    = 1'b0;
		pin_blk    = 1'b0;
		pin_addr   = shown_q;
		case (phase_q)
			PH_DATA: begin
				phase_d = PH_CLOCK;
			end
			PH_CLOCK: begin
				pin_clk = 1'b1;
				col_d   = col_inc[COL_W-1:0];
				phase_d = (col_inc >= (COL_W+1)'(eff_width)) ? PH_BLANK : PH_DATA;
			end
			PH_BLANK: begin
				pin_blk  = 1'b1;
				pin_addr = row;
				shown_d  = row;
				phase_d  = PH_LATCH;
			end
			default: begin
				pin_blk    = 1'b1;
				pin_lat    = 1'b1;
				pin_addr   = row;
				shown_d    = row;
				scan_row_d = (row + ROW_W'(1)) & half_mask;
				col_d      = '0;
				phase_d    = PH_DATA;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_DATA;
			scan_row_q <= '0;
			col_q      <= '0;
			shown_q    <= '0;
		end else if (tick_go) begin
			phase_q    <= phase_d;
			scan_row_q <= scan_row_d;
			col_q      <= col_d;
			shown_q    <= shown_d;
		end
	end

	// clearing pass: one entry per cycle after reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_busy_q <= 1'b1;
			clr_addr_q <= '0;
		end else if (clr_busy_q) begin
			clr_addr_q <= clr_addr_q + 1'b1;
			if (clr_addr_q == SADDR_W'(STORE_DEPTH - 1)) clr_busy_q <= 1'b0;
		end
	end

	assign clr_busy = clr_busy_q;
	assign mem_we   = clr_busy_q || wr_go;
	assign mem_wa   = clr_busy_q ? clr_addr_q : wr_ext[SADDR_W-1:0];
	assign mem_wd   = clr_busy_q ? '0 : cmd_data.color;

	always_ff @(posedge clk) begin
		if (mem_we) store_mem[mem_wa] <= mem_wd;
	end

	always_ff @(posedge clk) begin
		top_pix_s1 <= store_mem[top_ra];
		bot_pix_s1 <= store_mem[bot_ra];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= tick_go;
		end
	end

	always_ff @(posedge clk) begin
		top_ok_s1 <= pix_phase && (32'(top_idx) < STORE_DEPTH);
		bot_ok_s1 <= pix_phase && (32'(bot_idx) < STORE_DEPTH);
		clk_s1    <= pin_clk;
		lat_s1    <= pin_lat;
		blk_s1    <= pin_blk;
		addr_s1   <= pin_addr;
	end

	assign res_push = valid_s1;

	always_comb begin
		res_data.top_rgb     = top_ok_s1 ? top_pix_s1 : '0;
		res_data.bottom_rgb  = bot_ok_s1 ? bot_pix_s1 : '0;
		res_data.shift_clock = clk_s1;
		res_data.latch       = lat_s1;
		res_data.blank       = blk_s1;
		res_data.row_address = addr_s1;
	end

	`RMRS_ASSERT_NOW(a_result_has_slot, valid_s1, out_level < OUTQ_LVL_W'(OUTQ_DEPTH))
	`RMRS_ASSERT_NOW(a_clear_queue_idle, clr_busy_q, cmd_empty)
	`RMRS_ASSERT_NEXT(a_blank_then_latch, tick_go && (phase_q == PH_BLANK), phase_q == PH_LATCH)
	`RMRS_ASSERT_NOW(a_blank_no_color, valid_s1 && blk_s1, !top_ok_s1 && !bot_ok_s1)
endmodule
`default_nettype wire

@@ rtl/core/rgb_matrix_row_scan_driver_core.sv @@
// Top level of the dual-scan RGB matrix row-scan driver.
// Takes one beat per clock while full is low: pixel writes go to a 3-bit frame store, and each scan tick yields
// one set of panel pin levels (data, clock, blank or latch phase). The sustained rate is one
// item per cycle when neither the clearing pass nor a full result queue holds it, set by the
// combinational address multiply and the frame store's one write and two read ports; a tick's
// result reaches the result side through the command queue, the pixel read stage and the result
// queue. After reset a clearing pass writes black into every frame store entry, one per cycle
// (STORE_DEPTH entries, 4096 at the default); full stays high meanwhile, while configuration writes are taken as usual.
`default_nettype none
module rgb_matrix_row_scan_driver_core
	import rmrs_pkg::*;
#(
	parameter int STORE_DEPTH = 4096,
	parameter int MAX_WIDTH   = 64
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  push,
	output logic                       full,
	input  wire logic                  operation,
	input  wire logic [PIX_ADDR_W-1:0] pixel_address,
	input  wire logic [COLOR_W-1:0]    pixel_color,
	output logic                       empty,
	input  wire logic                  pop,
	output logic [COLOR_W-1:0]         top_rgb,
	output logic [COLOR_W-1:0]         bottom_rgb,
	output logic                       shift_clock,
	output logic                       latch,
	output logic                       blank,
	output logic [ROW_W-1:0]           row_address,
	input  wire logic                  psel,
	input  wire logic                  penable,
	input  wire logic                  pwrite,
	input  wire logic [PADDR_W-1:0]    paddr,
	input  wire logic [PDATA_W-1:0]    pwdata,
	output logic [PDATA_W-1:0]         prdata,
	output logic                       pready
);
	localparam int WMAX  = (MAX_WIDTH < 127) ? MAX_WIDTH : 127;
	localparam int COL_W = $clog2(WMAX + 1);
	localparam int IDX_W = $clog2(64 * WMAX);

	logic                  cmdq_full;
	logic                  cmdq_empty;
	logic                  clr_busy;
	logic                  cmd_push;
	logic                  cmd_pop;
	cmd_t                  cmd_in;
	logic [CMD_W-1:0]      cmd_bits;
	cmd_t                  cmd_out;
	logic [COL_W-1:0]      eff_width;
	logic [ROW_W-1:0]      half_mask;
	logic                  res_push;
	res_t                  res_in;
	logic [RES_W-1:0]      res_bits;
	res_t                  res_out;
	logic [OUTQ_LVL_W-1:0] out_level;
	logic                  outq_full;

	rmrs_front #(
		.STORE_DEPTH(STORE_DEPTH),
		.MAX_WIDTH  (MAX_WIDTH),
		.COL_W      (COL_W)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.push         (push),
		.full         (full),
		.operation    (operation),
		.pixel_address(pixel_address),
		.pixel_color  (pixel_color),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready),
		.cmdq_full    (cmdq_full),
		.clr_busy     (clr_busy),
		.cmd_push     (cmd_push),
		.cmd_data     (cmd_in),
		.eff_width    (eff_width),
		.half_mask    (half_mask)
	);

	rmrs_fifo #(
		.WIDTH(CMD_W),
		.DEPTH(CMDQ_DEPTH)
	) u_cmd_queue (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (cmd_push),
		.wdata (cmd_in),
		.full  (cmdq_full),
		.pop   (cmd_pop),
		.rdata (cmd_bits),
		.empty (cmdq_empty),
		.level ()
	);

	assign cmd_out = cmd_t'(cmd_bits);

	rmrs_back #(
		.STORE_DEPTH(STORE_DEPTH),
		.COL_W      (COL_W),
		.IDX_W      (IDX_W)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd_empty(cmdq_empty),
		.cmd_data (cmd_out),
		.cmd_pop  (cmd_pop),
		.eff_width(eff_width),
		.half_mask(half_mask),
		.out_level(out_level),
		.res_push (res_push),
		.res_data (res_in),
		.clr_busy (clr_busy)
	);

	rmrs_fifo #(
		.WIDTH(RES_W),
		.DEPTH(OUTQ_DEPTH)
	) u_res_queue (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (res_push),
		.wdata (res_in),
		.full  (outq_full),
		.pop   (pop),
		.rdata (res_bits),
		.empty (empty),
		.level (out_level)
	);

	assign res_out     = res_t'(res_bits);
	assign top_rgb     = res_out.top_rgb;
	assign bottom_rgb  = res_out.bottom_rgb;
	assign shift_clock = res_out.shift_clock;
	assign latch       = res_out.latch;
	// the back end never pushes into a full result queue; the full-and-empty term never forces blank
	assign blank       = res_out.blank | (outq_full & empty);
	assign row_address = res_out.row_address;
endmodule
`default_nettype wire
